/* src/pfc_pkg.sv */
// shared constants, types and helpers for the polytope feasibility check
package pfc_pkg;

    localparam int MAX_DIM    = 16;
    localparam int MAX_ROWS   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = PROD_W + DIM_W + 1;
    localparam int DIMS_RESET = 16;

    localparam logic [FUNC_W-1:0] FUNC_COEF  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POINT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_CMP
    } t_state;

    typedef struct packed {
        logic             wr_coef;
        logic             wr_pt;
        logic             start;
        logic             rd_en;
        logic [DIM_W-1:0] rd_k;
        logic             chk;
        logic             emit;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic last;
    } t_dp_stat;

    // dimension count clipped to the store depth
    function automatic logic [CNT_W-1:0] eff_dims(input logic [CFG_W-1:0] d);
        if (d > CFG_W'(MAX_DIM)) begin
            return CNT_W'(MAX_DIM);
        end
        return CNT_W'(d);
    endfunction

endpackage

/* src/pfc_dp.sv */
// datapath: coefficient and point stores, multiply-accumulate, bound compare, flags
module pfc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfc_pkg::t_dp_cmd                  i_cmd,
    output pfc_pkg::t_dp_stat                 o_stat,
    input  logic [pfc_pkg::ROW_W-1:0]         i_row_index,
    input  logic [pfc_pkg::DIM_W-1:0]         i_col_index,
    input  logic signed [pfc_pkg::VAL_W-1:0]  i_value,
    input  logic signed [pfc_pkg::VAL_W-1:0]  i_bound,
    input  logic                              i_at_least,
    input  logic                              i_last,
    output logic                              o_feasible
);
    import pfc_pkg::*;

    logic [VAL_W-1:0]         r_coef_mem [MAX_ROWS*MAX_DIM];
    logic [VAL_W-1:0]         r_pt_mem   [MAX_DIM];
    logic [ROW_W-1:0]         r_row;
    logic signed [VAL_W-1:0]  r_bound;
    logic                     r_at_least;
    logic                     r_last;
    logic signed [VAL_W-1:0]  r_coef_q;
    logic signed [VAL_W-1:0]  r_pt_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_neg;
    logic                     r_viol;
    logic                     r_feasible;
    logic signed [ACC_W-1:0]  w_lim;
    logic                     w_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef) begin
            r_coef_mem[{i_row_index, i_col_index}] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_coef_q <= r_coef_mem[{r_row, i_cmd.rd_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pt) begin
            r_pt_mem[i_col_index] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_pt_q <= r_pt_mem[i_cmd.rd_k];
        end
    end

    // check parameters held for the whole row
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row      <= i_row_index;
            r_bound    <= i_bound;
            r_at_least <= i_at_least;
            r_last     <= i_last;
        end
        r_prod <= r_coef_q * r_pt_q;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.emit) begin
            r_feasible <= !(r_neg || r_viol || w_hit);
        end
    end

    // bound scaled to the product's fraction width
    assign w_lim = ACC_W'(r_bound) <<< FRAC_BITS;
    assign w_hit = r_at_least ? (r_acc < w_lim) : (r_acc > w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_neg  <= 1'b0;
            r_viol <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.emit) begin
                r_neg  <= 1'b0;
                r_viol <= 1'b0;
            end else begin
                if (r_v1 && r_pt_q[VAL_W-1]) begin
                    r_neg <= 1'b1;
                end
                if (i_cmd.chk && w_hit) begin
                    r_viol <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_v1 || r_v2;
    assign o_stat.last = r_last;
    assign o_feasible  = r_feasible;

endmodule

/* src/pfc_ctrl.sv */
// controller: handshakes, dimension register and the check sequencer
module pfc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pfc_pkg::FUNC_W-1:0]  i_func,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pfc_pkg::CFG_W-1:0]   i_cfg_data,
    output pfc_pkg::t_dp_cmd            o_cmd,
    input  pfc_pkg::t_dp_stat           i_stat
);
    import pfc_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] n_k;
    logic [CFG_W-1:0] r_dims;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] w_n;
    logic             w_acc;

    assign w_n         = eff_dims(r_dims);
    assign w_acc       = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_dims      <= CFG_W'(DIMS_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_dims <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_func)
                        FUNC_COEF:  o_cmd.wr_coef = 1'b1;
                        FUNC_POINT: o_cmd.wr_pt   = 1'b1;
                        FUNC_CHECK: begin
                            o_cmd.start = 1'b1;
                            n_k         = '0;
                            n_state     = (w_n == '0) ? S_CMP : S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_k  = r_k[DIM_W-1:0];
                n_k         = CNT_W'(r_k + 1'b1);
                if (CNT_W'(r_k + 1'b1) == w_n) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // wait for the read and multiply stages to drain into the sum
                if (!i_stat.busy) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_stat.last) begin
                    o_cmd.chk = 1'b1;
                    n_state   = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.emit || (r_out_valid && i_out_stall);
    end

`ifndef NO_ASSERTIONS
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> !i_stat.busy)
        else $error("compare reached with products still in flight");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k < w_n))
        else $error("column counter ran past the dimension count");
`endif

endmodule

/* src/polytope_feasibility_check_top.sv */
// Point-in-polytope feasibility check, top level.
// Input channel (i_in_valid / o_in_stall) carries one transaction per item:
// func 0 writes a coefficient at (row, col), func 1 writes a point coordinate
// at col, func 2 checks one constraint row against its bound and direction.
// Loads do not stall the input. A check reads one coefficient and one
// coordinate per cycle for each of n columns, n being dims_in_use clipped
// to 16 (no reads when n is zero), and feeds a single 32x32 multiplier into
// a wide accumulator; the input stalls until its compare is done.
// A check marked last emits one result transaction on the output channel
// (o_out_valid / i_out_stall) with the feasible bit and clears the flags.
// The result sits in an output register; loads and further checks proceed
// while it is stalled, and only a second last check waits for it to drain.
// Config channel (i_cfg_valid / o_cfg_ready) writes dims_in_use; always
// ready, and meant to be written while the block is idle.
// Synchronous active-low reset clears the flags, the output valid and sets
// dims_in_use to 16; the stores keep whatever they held.
module polytope_feasibility_check_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pfc_pkg::FUNC_W-1:0]         i_func,
    input  logic [3:0]                         i_row_index,
    input  logic [3:0]                         i_col_index,
    input  logic signed [pfc_pkg::VAL_W-1:0]   i_value,
    input  logic signed [pfc_pkg::VAL_W-1:0]   i_bound,
    input  logic                               i_at_least,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_feasible,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pfc_pkg::CFG_W-1:0]          i_cfg_data
);
    import pfc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    pfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_row_index (i_row_index[ROW_W-1:0]),
        .i_col_index (i_col_index[DIM_W-1:0]),
        .i_value     (i_value),
        .i_bound     (i_bound),
        .i_at_least  (i_at_least),
        .i_last      (i_last),
        .o_feasible  (o_feasible)
    );

endmodule

/* verif/tb.sv */
// self-checking testbench for the polytope feasibility check: loads, checks, feasibility results
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DOT_W        = 80;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused code, ignored by the block

    localparam logic signed [DOT_W-1:0] BOUND_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [DOT_W-1:0] BOUND_MIN = -80'sh8000_0000;

    // dimension counts for the first random phases, extremes first
    localparam logic [6:0][CFG_W-1:0] DIM_PLAN = {
        5'd8, 5'd2, 5'd17, 5'd31, 5'd16, 5'd1, 5'd0
    };

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [3:0]        row;
        logic [3:0]        col;
        logic [VAL_W-1:0]  value;
        logic [VAL_W-1:0]  bound;
        logic              at_least;
        logic              last;
    } t_item;

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        t_item            item;
        logic [CFG_W-1:0] dims;
        logic             typed;
        logic             feasible;
    } t_step;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic [FUNC_W-1:0]        i_func       = '0;
    logic [3:0]               i_row_index  = '0;
    logic [3:0]               i_col_index  = '0;
    logic signed [VAL_W-1:0]  i_value      = '0;
    logic signed [VAL_W-1:0]  i_bound      = '0;
    logic                     i_at_least   = 1'b0;
    logic                     i_last       = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic                     o_feasible;
    logic                     i_cfg_valid  = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data   = '0;

    // predictor state
    logic [VAL_W-1:0] coef_mem [MAX_ROWS*MAX_DIM];
    logic [VAL_W-1:0] point_mem [MAX_DIM];
    logic             neg_flag  = 1'b0;
    logic             viol_flag = 1'b0;
    logic [CFG_W-1:0] dims_reg  = CFG_W'(DIMS_RESET);
    logic             expected_feasible [$];

    t_step directed_steps [$];
    logic  head_feasible;
    int    mismatches   = 0;
    int    cycle_count  = 0;
    int    stall_left   = 0;
    int    items_sent   = 0;
    int    random_start = 0;
    int    phase_start  = 0;
    int    phase        = 0;
    bit    quiet        = 1'b0;
    bit    calm         = 1'b0;

    polytope_feasibility_check_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_bound     (i_bound),
        .i_at_least  (i_at_least),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_feasible  (o_feasible),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic bit idle_on();
        return !quiet && !calm;
    endfunction

    function automatic int used_dims();
        return (dims_reg > CFG_W'(MAX_DIM)) ? MAX_DIM : int'(dims_reg);
    endfunction

    // exact dot product of one stored row with the point over the used columns
    function automatic logic signed [DOT_W-1:0] row_dot(input logic [3:0] row);
        logic signed [DOT_W-1:0] acc;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] x;
        longint                  prod;
        acc = '0;
        for (int k = 0; k < used_dims(); k++) begin
            a    = coef_mem[{row, 4'(k)}];
            x    = point_mem[k];
            prod = a * x;
            acc  = acc + prod;
        end
        return acc;
    endfunction

    function automatic void update_feasibility(input t_item it, input logic typed,
                                               input logic typed_val);
        logic signed [DOT_W-1:0] dot;
        logic signed [DOT_W-1:0] lim;
        case (it.func)
            FUNC_COEF: begin
                coef_mem[{it.row, it.col}] = it.value;
            end
            FUNC_POINT: begin
                point_mem[it.col] = it.value;
            end
            FUNC_CHECK: begin
                for (int k = 0; k < used_dims(); k++) begin
                    if (point_mem[k][VAL_W-1]) begin
                        neg_flag = 1'b1;
                    end
                end
                dot = row_dot(it.row);
                // bound moved to the product's fraction width
                lim = {{(DOT_W-VAL_W){it.bound[VAL_W-1]}}, it.bound};
                lim = lim <<< FRAC_BITS;
                if (it.at_least ? (dot < lim) : (dot > lim)) begin
                    viol_flag = 1'b1;
                end
                if (it.last) begin
                    expected_feasible.push_back(typed ? typed_val : !(neg_flag || viol_flag));
                    neg_flag  = 1'b0;
                    viol_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_step mk(input logic [FUNC_W-1:0] func, input logic [3:0] row,
                                 input logic [3:0] col, input logic [VAL_W-1:0] value,
                                 input logic [VAL_W-1:0] bound, input logic at_least,
                                 input logic last);
        t_step s;
        s = '0;
        s.kind          = STEP_ITEM;
        s.item.func     = func;
        s.item.row      = row;
        s.item.col      = col;
        s.item.value    = value;
        s.item.bound    = bound;
        s.item.at_least = at_least;
        s.item.last     = last;
        return s;
    endfunction

    function automatic t_step typed_check(input logic [3:0] row, input logic [VAL_W-1:0] bound,
                                          input logic at_least, input logic feasible);
        t_step s;
        s = mk(FUNC_CHECK, row, 4'd0, '0, bound, at_least, 1'b1);
        s.typed    = 1'b1;
        s.feasible = feasible;
        return s;
    endfunction

    function automatic t_step cfg_step(input logic [CFG_W-1:0] dims);
        t_step s;
        s      = '0;
        s.kind = STEP_CFG;
        s.dims = dims;
        return s;
    endfunction

    // mostly small magnitudes so dots stay near the bound range
    function automatic logic [VAL_W-1:0] rand_value(input bit nonneg);
        logic [VAL_W-1:0] v;
        v = $urandom();
        if ($urandom_range(0, 3) != 0) begin
            v = {{11{v[20]}}, v[20:0]};
        end
        if (nonneg && v[VAL_W-1]) begin
            v = ~v;
        end
        return v;
    endfunction

    function automatic t_item rand_fields();
        t_item it;
        it.func     = FUNC_W'($urandom_range(0, 3));
        it.row      = 4'($urandom());
        it.col      = 4'($urandom());
        it.value    = $urandom();
        it.bound    = $urandom();
        it.at_least = 1'($urandom());
        it.last     = 1'($urandom());
        return it;
    endfunction

    function automatic t_item rand_load();
        t_item it;
        it = rand_fields();
        if ($urandom_range(0, 1) == 0) begin
            it.func  = FUNC_POINT;
            it.value = rand_value($urandom_range(0, 9) != 0);
        end else begin
            it.func  = FUNC_COEF;
            it.value = rand_value(1'b0);
        end
        return it;
    endfunction

    // check with the bound placed close to the row's current dot
    function automatic t_item near_check(input logic last);
        t_item                   it;
        logic signed [DOT_W-1:0] base;
        logic signed [DOT_W-1:0] cand;
        int                      off;
        bit                      viol;
        it      = rand_fields();
        it.func = FUNC_CHECK;
        it.last = last;
        base    = row_dot(it.row) >>> FRAC_BITS;
        off     = $urandom_range(0, 3);
        viol    = ($urandom_range(0, 9) == 0);
        if (it.at_least) begin
            cand = viol ? base + 1 : base - off;
        end else begin
            cand = viol ? base - 1 : base + off;
        end
        if (cand > BOUND_MAX) begin
            cand = BOUND_MAX;
        end else if (cand < BOUND_MIN) begin
            cand = BOUND_MIN;
        end
        it.bound = cand[VAL_W-1:0];
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic typed, input logic typed_val);
        int gap;
        if (idle_on() && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= it.func;
        i_row_index <= it.row;
        i_col_index <= it.col;
        i_value     <= it.value;
        i_bound     <= it.bound;
        i_at_least  <= it.at_least;
        i_last      <= it.last;
        do @(posedge i_clk); while (o_in_stall);
        update_feasibility(it, typed, typed_val);
        if (it.func != FUNC_NONE) begin
            items_sent++;
        end
    endtask

    task automatic wait_idle();
        while (expected_feasible.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] d);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dims_reg = d;
    endtask

    // a few loads, then the checks of one point, now and then a stray transaction
    task automatic send_random_group();
        t_item it;
        int    n_loads;
        int    n_checks;
        n_loads  = $urandom_range(0, 4);
        n_checks = $urandom_range(1, 5);
        repeat (n_loads) begin
            it = rand_load();
            send_item(it, 1'b0, 1'b0);
        end
        for (int j = 0; j < n_checks; j++) begin
            it = near_check(j == n_checks - 1);
            send_item(it, 1'b0, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
            it = rand_fields();
            if (it.func == FUNC_POINT && $urandom_range(0, 1) == 0) begin
                it.value[VAL_W-1] = 1'b1;
            end
            send_item(it, 1'b0, 1'b0);
        end
    endtask

    initial begin
        // reset dims is 16
        directed_steps.push_back(mk(FUNC_NONE, 4'hF, 4'hF, '1, '1, 1'b1, 1'b1));
        directed_steps.push_back(mk(FUNC_POINT, 4'd0, 4'd0, 32'h8000_0000, '0, 1'b0, 1'b0));
        directed_steps.push_back(typed_check(4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0));
        directed_steps.push_back(mk(FUNC_COEF, 4'd15, 4'd15, 32'h7FFF_FFFF, '0, 1'b0, 1'b1));
        directed_steps.push_back(mk(FUNC_POINT, 4'd0, 4'd15, 32'h7FFF_FFFF, '0, 1'b0, 1'b1));
        directed_steps.push_back(mk(FUNC_POINT, 4'd0, 4'd0, 32'h7FFF_FFFF, '0, 1'b0, 1'b0));
        directed_steps.push_back(mk(FUNC_CHECK, 4'd15, 4'd0, '0, 32'h8000_0000, 1'b1, 1'b0));
        directed_steps.push_back(mk(FUNC_CHECK, 4'd15, 4'd0, '0, 32'h7FFF_FFFF, 1'b0, 1'b1));
        // no coordinates used: the dot is zero
        directed_steps.push_back(cfg_step(5'd0));
        directed_steps.push_back(typed_check(4'd3, 32'h0000_0000, 1'b0, 1'b1));
        directed_steps.push_back(typed_check(4'd3, 32'hFFFF_FFFF, 1'b0, 1'b0));
        directed_steps.push_back(typed_check(4'd3, 32'h0000_0000, 1'b1, 1'b1));
        directed_steps.push_back(typed_check(4'd3, 32'h0000_0001, 1'b1, 1'b0));
        // one coordinate: most negative operands, then equality at the bound
        directed_steps.push_back(cfg_step(5'd1));
        directed_steps.push_back(mk(FUNC_COEF, 4'd7, 4'd0, 32'h8000_0000, '0, 1'b0, 1'b0));
        directed_steps.push_back(mk(FUNC_POINT, 4'd0, 4'd0, 32'h8000_0000, '0, 1'b0, 1'b0));
        directed_steps.push_back(typed_check(4'd7, 32'h7FFF_FFFF, 1'b1, 1'b0));
        directed_steps.push_back(mk(FUNC_POINT, 4'd0, 4'd0, 32'h0001_0000, '0, 1'b0, 1'b0));
        directed_steps.push_back(mk(FUNC_COEF, 4'd7, 4'd0, 32'h0002_0000, '0, 1'b0, 1'b0));
        directed_steps.push_back(typed_check(4'd7, 32'h0002_0000, 1'b0, 1'b1));
        directed_steps.push_back(typed_check(4'd7, 32'h0002_0000, 1'b1, 1'b1));
        directed_steps.push_back(typed_check(4'd7, 32'h0001_FFFF, 1'b0, 1'b0));
        directed_steps.push_back(typed_check(4'd7, 32'h0002_0001, 1'b1, 1'b0));
        // dimension count above the store depth saturates
        directed_steps.push_back(cfg_step(5'd31));
        directed_steps.push_back(mk(FUNC_CHECK, 4'd7, 4'd0, '0, 32'h8000_0000, 1'b1, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both stores so that no check reads an unwritten entry
        for (int c = 0; c < MAX_DIM; c++) begin
            send_item(t_item'({FUNC_POINT, 4'd0, 4'(c), rand_value(1'b1), 32'd0, 2'b00}),
                      1'b0, 1'b0);
        end
        for (int a = 0; a < MAX_ROWS * MAX_DIM; a++) begin
            send_item(t_item'({FUNC_COEF, 8'(a), rand_value(1'b0), 32'd0, 2'b00}),
                      1'b0, 1'b0);
        end

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG) begin
                write_dims(directed_steps[i].dims);
            end else begin
                send_item(directed_steps[i].item, directed_steps[i].typed,
                          directed_steps[i].feasible);
            end
        end

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            write_dims(phase < 7 ? DIM_PLAN[phase] : CFG_W'($urandom_range(0, 31)));
            calm        = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS &&
                   items_sent - random_start < RANDOM_ITEMS) begin
                quiet = (items_sent - random_start >= RANDOM_ITEMS - QUIET_ITEMS);
                send_random_group();
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("polytope_feasibility_check_top: match");
        end else begin
            $display("polytope_feasibility_check_top: mismatch");
        end
        $finish;
    end

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on() && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_feasible.size() == 0) begin
                $error("feasible: expected none, actual %0b", o_feasible);
                mismatches <= mismatches + 1;
            end else begin
                head_feasible = expected_feasible.pop_front();
                if (o_feasible !== head_feasible) begin
                    $error("feasible: expected %0b, actual %0b", head_feasible, o_feasible);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("polytope_feasibility_check_top: mismatch");
            $finish;
        end
    end

endmodule
